[sv/atc_pkg.sv]
// ----------------------------------------------------------------------------
// atc_pkg
// Shared types, codes and constants of the text console cursor engine.
// ----------------------------------------------------------------------------
package atc_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_CELL_WIDTH    = 2'd0;
	localparam logic [1:0] REG_CELL_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd2;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd3;

	localparam logic [6:0]  RST_CELL_WIDTH    = 7'd8;
	localparam logic [6:0]  RST_CELL_HEIGHT   = 7'd8;
	localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd1024;
	localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd768;
	localparam logic [23:0] RST_COLOR         = 24'hFFFFFF;

	// byte codes
	localparam logic [7:0] CH_ESC  = 8'h1B;
	localparam logic [7:0] CH_LBR  = 8'h5B;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_SGR  = 8'h6D;
	localparam logic [7:0] CH_CUP  = 8'h48;
	localparam logic [7:0] CH_ED   = 8'h4A;
	localparam logic [7:0] CH_EL   = 8'h4B;
	localparam logic [7:0] CH_D0   = 8'h30;
	localparam logic [7:0] CH_D9   = 8'h39;

	// SGR color ranges and erase modes
	localparam logic [15:0] SGR_FG_LO     = 16'd30;
	localparam logic [15:0] SGR_FG_HI     = 16'd37;
	localparam logic [15:0] SGR_BRIGHT_LO = 16'd90;
	localparam logic [15:0] SGR_BRIGHT_HI = 16'd97;
	localparam logic [15:0] SGR_BRIGHT_OFS = 16'd82;
	localparam logic [15:0] SGR_RESET     = 16'd0;
	localparam logic [15:0] ERASE_BELOW   = 16'd0;
	localparam logic [15:0] ERASE_ALL     = 16'd2;
	localparam logic [15:0] PARAM_MAX     = 16'd65535;

	// parser phases
	localparam logic [1:0] PH_GROUND = 2'd0;
	localparam logic [1:0] PH_ESC    = 2'd1;
	localparam logic [1:0] PH_CSI    = 2'd2;

	localparam int QDEPTH = 2;
	localparam int QAW    = 1;

	typedef enum logic [3:0] {
		BC_OTHER, BC_DIGIT, BC_SEMI, BC_ESC, BC_LBRACK, BC_LF, BC_CR, BC_TAB,
		BC_SGR, BC_CUP, BC_ED, BC_EL
	} byte_class_t;

	typedef enum logic [2:0] {
		OP_ECHO   = 3'd0,
		OP_GLYPH  = 3'd1,
		OP_FILL   = 3'd2,
		OP_SCROLL = 3'd3,
		OP_CLEAR  = 3'd4
	} cmd_op_t;

	typedef enum logic [3:0] {
		BK_IDLE, BK_LOAD, BK_DECODE, BK_FINAL, BK_SGR, BK_DIV, BK_POST, BK_OUT
	} back_state_t;

	typedef enum logic {DK_TAB, DK_ERASE} div_kind_t;

	typedef struct packed {
		logic [6:0]  cell_width;
		logic [6:0]  cell_height;
		logic [12:0] screen_width;
		logic [12:0] screen_height;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  char_byte;
		logic        message_start;
		logic [23:0] message_color;
		byte_class_t cls;
	} queue_item_t;

	typedef struct packed {
		cmd_op_t     op;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [12:0] rect_w;
		logic [12:0] rect_h;
		logic [23:0] draw_color;
		logic [7:0]  glyph_code;
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic        echo_valid;
		logic [7:0]  echo_byte;
		logic        last;
	} result_t;

	function automatic byte_class_t classify(input logic [7:0] b);
		byte_class_t c;
		c = BC_OTHER;
		if (b >= CH_D0 && b <= CH_D9) c = BC_DIGIT;
		else begin
			case (b)
				CH_SEMI: c = BC_SEMI;
				CH_ESC:  c = BC_ESC;
				CH_LBR:  c = BC_LBRACK;
				CH_LF:   c = BC_LF;
				CH_CR:   c = BC_CR;
				CH_TAB:  c = BC_TAB;
				CH_SGR:  c = BC_SGR;
				CH_CUP:  c = BC_CUP;
				CH_ED:   c = BC_ED;
				CH_EL:   c = BC_EL;
				default: c = BC_OTHER;
			endcase
		end
		return c;
	endfunction

	function automatic logic [23:0] palette(input logic [3:0] idx);
		logic [23:0] c;
		case (idx)
			4'd0:    c = 24'h000000;
			4'd1:    c = 24'hAA0000;
			4'd2:    c = 24'h00AA00;
			4'd3:    c = 24'hAAAA00;
			4'd4:    c = 24'h0000AA;
			4'd5:    c = 24'hAA00AA;
			4'd6:    c = 24'h00AAAA;
			4'd7:    c = 24'hAAAAAA;
			4'd8:    c = 24'h555555;
			4'd9:    c = 24'hFF5555;
			4'd10:   c = 24'h55FF55;
			4'd11:   c = 24'hFFFF55;
			4'd12:   c = 24'h5555FF;
			4'd13:   c = 24'hFF55FF;
			4'd14:   c = 24'h55FFFF;
			default: c = 24'hFFFFFF;
		endcase
		return c;
	endfunction

endpackage

[sv/atc_front.sv]
// ----------------------------------------------------------------------------
// atc_front
// Input side: takes byte transactions, classifies them, queues two entries.
// ----------------------------------------------------------------------------
module atc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [31:0]          s_axis_tdata,  // char_byte, message_color
	input  logic                 s_axis_tuser,  // message_start
	output logic                 q_valid,
	input  logic                 q_pop,
	output atc_pkg::queue_item_t q_item
);
	import atc_pkg::*;

	queue_item_t      mem [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QAW:0]     count_q;
	logic             push;

	assign s_axis_tready = (count_q != (QAW+1)'(QDEPTH));
	assign q_valid       = (count_q != '0);
	assign push          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= '{char_byte: s_axis_tdata[7:0],
			                   message_start: s_axis_tuser,
			                   message_color: s_axis_tdata[31:8],
			                   cls: classify(s_axis_tdata[7:0])};
		end
		if (q_pop) begin
			q_item <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !q_pop) count_q <= count_q + 1'b1;
			else if (!push && q_pop) count_q <= count_q - 1'b1;
		end
	end

endmodule

[sv/atc_div.sv]
// ----------------------------------------------------------------------------
// atc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module atc_div #(
	parameter int DDW = 16,
	parameter int DVW = 11
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DDW-1:0] dividend,
	input  logic [DVW-1:0] divisor,
	output logic           done,
	output logic [DDW-1:0] quotient
);
	localparam int CW = $clog2(DDW+1);

	logic [DDW-1:0] q_q;
	logic [DVW-1:0] r_q, d_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q, done_q;
	logic [DVW:0]   trial;
	logic           ge;

	assign trial    = {r_q, q_q[DDW-1]};
	assign ge       = (trial >= {1'b0, d_q});
	assign done     = done_q;
	assign quotient = q_q;

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[DDW-2:0], ge};
			r_q <= ge ? DVW'(trial - {1'b0, d_q}) : trial[DVW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DDW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) busy_q <= 1'b0;
			end
		end
	end

endmodule

[sv/atc_back.sv]
// ----------------------------------------------------------------------------
// atc_back
// Execution side: CSI parser, cursor, colors and command generation.
// ----------------------------------------------------------------------------
module atc_back #(
	parameter int MAX_PARAMS  = 4,
	parameter int TAB_CELLS   = 4,
	parameter int COORD_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  atc_pkg::cfg_t        cfg,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  atc_pkg::queue_item_t q_item,
	output logic                 res_valid,
	input  logic                 res_ready,
	output atc_pkg::result_t     res
);
	import atc_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int DDW = (CB > 13) ? CB : 13;
	localparam int XW  = DDW + 1;
	localparam int TWW = 7 + $clog2(TAB_CELLS);
	localparam int TPW = XW + TWW;
	localparam int PCW = $clog2(MAX_PARAMS + 1);
	localparam int PIW = $clog2(MAX_PARAMS);
	localparam int MW  = 23;
	localparam logic [CB-1:0] CMAX = '1;

	back_state_t     state_q, state_d;
	logic [7:0]      byte_q;
	byte_class_t     cls_q;
	logic [CB-1:0]   cur_x_q, cur_x_d, cur_y_q, cur_y_d;
	logic [23:0]     act_q, act_d, base_q, base_d;
	logic [1:0]      phase_q, phase_d;
	logic [15:0]     pstore_q [MAX_PARAMS];
	logic [PCW-1:0]  pcnt_q, pcnt_d;
	logic [15:0]     acc_q, acc_d;
	logic            seen_q, seen_d;
	cmd_t            res_q [2];
	cmd_t            res_d [2];
	logic [1:0]      rn_q, rn_d;
	logic            ridx_q, ridx_d;
	logic [PIW-1:0]  sgr_i_q, sgr_i_d;
	div_kind_t       divk_q, divk_d;
	logic            push_en;
	logic [15:0]     push_val;
	logic            div_start, div_done;
	logic [DDW-1:0]  div_dvd, div_quo;
	logic [TWW-1:0]  div_dvs;

	// derived geometry
	logic [6:0]      cw_e, ch_e;
	logic [12:0]     maxx, maxy;
	logic [TWW-1:0]  tw;
	logic [DDW-1:0]  cx, cy;
	logic [12:0]     w_rem;
	cmd_t            fill_row;

	assign cw_e = (cfg.cell_width == '0) ? 7'd1 : cfg.cell_width;
	assign ch_e = (cfg.cell_height == '0) ? 7'd1 : cfg.cell_height;
	assign maxx = (cfg.screen_width >= 13'(cw_e)) ? cfg.screen_width - 13'(cw_e) : '0;
	assign maxy = (cfg.screen_height >= 13'(ch_e)) ? cfg.screen_height - 13'(ch_e) : '0;
	assign tw   = TWW'(cw_e) * TWW'(TAB_CELLS);
	assign cx   = DDW'(cur_x_q);
	assign cy   = DDW'(cur_y_q);
	assign w_rem = (DDW'(cfg.screen_width) > cx) ? 13'(DDW'(cfg.screen_width) - cx) : '0;

	always_comb begin
		fill_row = '0;
		fill_row.op = OP_FILL;
		fill_row.pos_x = 16'(cur_x_q);
		fill_row.pos_y = 16'(cur_y_q);
		fill_row.rect_w = w_rem;
		fill_row.rect_h = 13'(ch_e);
	end

	// text cursor movement before wrap
	logic [CB-1:0]  tx_nx, tx_ny;
	logic           tx_glyph;
	logic [XW-1:0]  sum_x, sum_y;
	logic [TPW-1:0] tab_prod;

	assign sum_x    = XW'(cx) + XW'(cw_e);
	assign sum_y    = XW'(cy) + XW'(ch_e);
	assign tab_prod = TPW'(XW'(div_quo) + XW'(1)) * TPW'(tw);

	always_comb begin
		tx_nx    = cur_x_q;
		tx_ny    = cur_y_q;
		tx_glyph = 1'b0;
		if (state_q == BK_POST) begin
			tx_nx = (tab_prod > TPW'(CMAX)) ? CMAX : CB'(tab_prod);
		end else begin
			case (cls_q)
				BC_LF: begin
					tx_nx = '0;
					tx_ny = (sum_y > XW'(CMAX)) ? CMAX : CB'(sum_y);
				end
				BC_CR: tx_nx = '0;
				default: begin
					tx_nx = (sum_x > XW'(CMAX)) ? CMAX : CB'(sum_x);
					tx_glyph = (sum_x <= XW'(cfg.screen_width)) &&
					           (sum_y <= XW'(cfg.screen_height));
				end
			endcase
		end
	end

	// wrap and scroll
	logic [CB-1:0] fx, fy, wy;
	logic [XW-1:0] wsum;
	logic          scroll;

	assign wsum = XW'(tx_ny) + XW'(ch_e);
	always_comb begin
		wy = (wsum > XW'(CMAX)) ? CMAX : CB'(wsum);
		if (DDW'(tx_nx) > DDW'(maxx)) begin
			fx = '0;
			fy = wy;
		end else begin
			fx = tx_nx;
			fy = tx_ny;
		end
		scroll = (DDW'(fy) > DDW'(maxy)) && (13'(ch_e) < cfg.screen_height);
		if (scroll) fy = (DDW'(fy) >= DDW'(ch_e)) ? CB'(DDW'(fy) - DDW'(ch_e)) : '0;
	end

	// parameter reads
	logic [15:0]    p0, p1, pg, row, col, mode;
	logic [MW-1:0]  prod_y, prod_x;
	logic [19:0]    acc10;
	logic [DDW+6:0] nch;

	assign p0     = pstore_q[0];
	assign p1     = pstore_q[1];
	assign pg     = pstore_q[sgr_i_q];
	assign row    = (pcnt_q != '0) ? p0 : 16'd1;
	assign col    = (pcnt_q > PCW'(1)) ? p1 : 16'd1;
	assign mode   = (pcnt_q != '0) ? p0 : ERASE_BELOW;
	assign prod_y = (row == '0) ? '0 : MW'(row - 16'd1) * MW'(ch_e);
	assign prod_x = (col == '0) ? '0 : MW'(col - 16'd1) * MW'(cw_e);
	assign acc10  = 20'(acc_q) * 20'd10 + 20'(byte_q[3:0]);
	assign nch    = (DDW+7)'(div_quo) * (DDW+7)'(ch_e);

	always_comb begin
		logic [1:0] k;
		k          = '0;
		state_d    = state_q;
		cur_x_d    = cur_x_q;
		cur_y_d    = cur_y_q;
		act_d      = act_q;
		base_d     = base_q;
		phase_d    = phase_q;
		pcnt_d     = pcnt_q;
		acc_d      = acc_q;
		seen_d     = seen_q;
		res_d      = res_q;
		rn_d       = rn_q;
		ridx_d     = ridx_q;
		sgr_i_d    = sgr_i_q;
		divk_d     = divk_q;
		push_en    = 1'b0;
		push_val   = acc_q;
		div_start  = 1'b0;
		div_dvd    = cx;
		div_dvs    = tw;
		q_pop      = 1'b0;
		res_valid  = 1'b0;

		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = BK_LOAD;
				end
			end
			BK_LOAD: begin
				rn_d   = '0;
				ridx_d = 1'b0;
				if (q_item.message_start) begin
					phase_d = PH_GROUND;
					pcnt_d  = '0;
					acc_d   = '0;
					seen_d  = 1'b0;
					base_d  = q_item.message_color;
					act_d   = q_item.message_color;
				end
				state_d = BK_DECODE;
			end
			BK_DECODE: begin
				state_d = BK_OUT;
				case (phase_q)
					PH_ESC: begin
						if (cls_q == BC_LBRACK) begin
							phase_d = PH_CSI;
							pcnt_d  = '0;
							acc_d   = '0;
							seen_d  = 1'b0;
						end else begin
							phase_d = PH_GROUND;
						end
					end
					PH_CSI: begin
						if (cls_q == BC_DIGIT) begin
							acc_d   = (acc10 > 20'(PARAM_MAX)) ? PARAM_MAX : acc10[15:0];
							seen_d  = 1'b1;
							state_d = BK_IDLE;
						end else begin
							push_en  = (cls_q == BC_SEMI) || seen_q;
							push_val = seen_q ? acc_q : '0;
							acc_d    = '0;
							seen_d   = 1'b0;
							if (push_en && pcnt_q < PCW'(MAX_PARAMS)) pcnt_d = pcnt_q + 1'b1;
							if (cls_q != BC_SEMI) begin
								phase_d = PH_GROUND;
								state_d = BK_FINAL;
							end
						end
					end
					default: begin
						phase_d = PH_GROUND;
						if (cls_q == BC_ESC) begin
							phase_d = PH_ESC;
						end else if (cls_q == BC_TAB) begin
							div_start = 1'b1;
							div_dvd   = cx;
							div_dvs   = tw;
							divk_d    = DK_TAB;
							state_d   = BK_DIV;
						end else begin
							if (tx_glyph) begin
								res_d[0]            = '0;
								res_d[0].op         = OP_GLYPH;
								res_d[0].pos_x      = 16'(cur_x_q);
								res_d[0].pos_y      = 16'(cur_y_q);
								res_d[0].draw_color = act_q;
								res_d[0].glyph_code = byte_q;
								k = 2'd1;
							end
							if (scroll) begin
								res_d[k[0]]    = '0;
								res_d[k[0]].op = OP_SCROLL;
								k = k + 2'd1;
							end
							rn_d    = k;
							cur_x_d = fx;
							cur_y_d = fy;
						end
					end
				endcase
			end
			BK_FINAL: begin
				state_d = BK_OUT;
				case (cls_q)
					BC_SGR: begin
						if (pcnt_q == '0) act_d = base_q;
						else begin
							sgr_i_d = '0;
							state_d = BK_SGR;
						end
					end
					BC_CUP: begin
						cur_y_d = (prod_y > MW'(CMAX)) ? CMAX : CB'(prod_y);
						cur_x_d = (prod_x > MW'(CMAX)) ? CMAX : CB'(prod_x);
					end
					BC_ED: begin
						if (mode == ERASE_ALL) begin
							res_d[0]    = '0;
							res_d[0].op = OP_CLEAR;
							rn_d        = 2'd1;
							cur_x_d     = '0;
							cur_y_d     = '0;
						end else if (mode == ERASE_BELOW && cy <= DDW'(maxy)) begin
							div_start = 1'b1;
							div_dvd   = DDW'(maxy) - cy;
							div_dvs   = TWW'(ch_e);
							divk_d    = DK_ERASE;
							state_d   = BK_DIV;
						end
					end
					BC_EL: begin
						if (mode == ERASE_BELOW) begin
							res_d[0] = fill_row;
							rn_d     = 2'd1;
						end
					end
					default: ;
				endcase
			end
			BK_SGR: begin
				if (pg >= SGR_FG_LO && pg <= SGR_FG_HI)
					act_d = palette(4'(pg - SGR_FG_LO));
				else if (pg >= SGR_BRIGHT_LO && pg <= SGR_BRIGHT_HI)
					act_d = palette(4'(pg - SGR_BRIGHT_OFS));
				else if (pg == SGR_RESET)
					act_d = base_q;
				sgr_i_d = sgr_i_q + 1'b1;
				if (PCW'(sgr_i_q) + PCW'(1) == pcnt_q) state_d = BK_OUT;
			end
			BK_DIV: begin
				if (div_done) state_d = BK_POST;
			end
			BK_POST: begin
				state_d = BK_OUT;
				if (divk_q == DK_TAB) begin
					if (scroll) begin
						res_d[0]    = '0;
						res_d[0].op = OP_SCROLL;
						rn_d        = 2'd1;
					end
					cur_x_d = fx;
					cur_y_d = fy;
				end else begin
					res_d[0] = fill_row;
					rn_d     = 2'd1;
					if (div_quo != '0) begin
						res_d[1]        = '0;
						res_d[1].op     = OP_FILL;
						res_d[1].pos_y  = 16'(sum_y);
						res_d[1].rect_w = cfg.screen_width;
						res_d[1].rect_h = 13'(nch);
						rn_d            = 2'd2;
					end
				end
			end
			BK_OUT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					if (res.last) state_d = BK_IDLE;
					else ridx_d = 1'b1;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		res            = '0;
		res.cmd        = (rn_q == '0) ? cmd_t'('0) : res_q[ridx_q];
		res.echo_valid = !ridx_q;
		res.echo_byte  = ridx_q ? 8'd0 : byte_q;
		res.last       = (rn_q != 2'd2) || ridx_q;
	end

	atc_div #(.DDW(DDW), .DVW(TWW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (state_q == BK_LOAD) begin
			byte_q <= q_item.char_byte;
			cls_q  <= q_item.cls;
		end
		if (push_en && pcnt_q < PCW'(MAX_PARAMS)) pstore_q[PIW'(pcnt_q)] <= push_val;
		res_q   <= res_d;
		sgr_i_q <= sgr_i_d;
		divk_q  <= divk_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cur_x_q <= '0;
			cur_y_q <= '0;
			act_q   <= RST_COLOR;
			base_q  <= RST_COLOR;
			phase_q <= PH_GROUND;
			pcnt_q  <= '0;
			acc_q   <= '0;
			seen_q  <= 1'b0;
			rn_q    <= '0;
			ridx_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cur_x_q <= cur_x_d;
			cur_y_q <= cur_y_d;
			act_q   <= act_d;
			base_q  <= base_d;
			phase_q <= phase_d;
			pcnt_q  <= pcnt_d;
			acc_q   <= acc_d;
			seen_q  <= seen_d;
			rn_q    <= rn_d;
			ridx_q  <= ridx_d;
		end
	end

endmodule

[sv/ansi_text_console_cursor_engine.sv]
// ----------------------------------------------------------------------------
// ansi_text_console_cursor_engine
// Console byte stream to glyph, fill, scroll and clear commands.
// ----------------------------------------------------------------------------
// Input stream: one console byte per transaction, tuser marks the first byte
// of a message and tdata carries its base color. Output stream: one command
// per transaction with the serial echo of the byte on the first one; tlast
// marks the final command of a byte. Digits inside a CSI give no output.
// Config writes (cfg_we/cfg_index/cfg_data) must be made only while idle.
// A two-entry input queue keeps accepting while the executor is busy.
// Per byte the executor steps through pop, load and decode, then one output
// step per command for plain text and controls; a digit inside CSI ends after
// decode. A CSI final byte adds a final step and SGR one more step per
// parameter. Tab runs the shared bit-serial divider, then a post step;
// erase-below also passes through the final step before the divider.
// The output register holds a command until the receiver takes it; a
// stalled receiver stops the executor, then the queue fills and tready drops.
// Reset: cursor at 0,0, colors white, parser in ground state, config at
// 8x8 cells on 1024x768; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ansi_text_console_cursor_engine #(
	parameter int MAX_PARAMS = 4,
	parameter int TAB_CELLS  = 4,
	parameter int COORD_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [31:0]   s_axis_tdata,   // char_byte, message_color
	input  logic          s_axis_tuser,   // message_start
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [103:0]  m_axis_tdata,   // pos_x, pos_y, rect_w, rect_h,
	                                      // draw_color, glyph_code, echo_byte
	output logic [3:0]    m_axis_tuser,   // op, echo_valid
	output logic          m_axis_tlast,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [12:0]   cfg_data
);
	import atc_pkg::*;

	cfg_t        cfg_q;
	queue_item_t q_item;
	logic        q_valid, q_pop;
	result_t     res, out_q;
	logic        res_valid, res_ready, ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_width    <= RST_CELL_WIDTH;
			cfg_q.cell_height   <= RST_CELL_HEIGHT;
			cfg_q.screen_width  <= RST_SCREEN_WIDTH;
			cfg_q.screen_height <= RST_SCREEN_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CELL_WIDTH:    cfg_q.cell_width    <= cfg_data[6:0];
				REG_CELL_HEIGHT:   cfg_q.cell_height   <= cfg_data[6:0];
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data;
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data;
				default: ;
			endcase
		end
	end

	atc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.q_item        (q_item)
	);

	atc_back #(
		.MAX_PARAMS (MAX_PARAMS),
		.TAB_CELLS  (TAB_CELLS),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register
	assign res_ready = !ov_q || m_axis_tready;

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (res_ready) ov_q <= res_valid;
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {6'd0, out_q.echo_byte, out_q.cmd.glyph_code,
	                        out_q.cmd.draw_color, out_q.cmd.rect_h, out_q.cmd.rect_w,
	                        out_q.cmd.pos_y, out_q.cmd.pos_x};
	assign m_axis_tuser  = {out_q.echo_valid, out_q.cmd.op};
	assign m_axis_tlast  = out_q.last;

endmodule

[sv/atc_checker.sv]
// ----------------------------------------------------------------------------
// atc_checker
// Port-level checks on the command stream of the console engine.
// ----------------------------------------------------------------------------
module atc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [103:0] m_axis_tdata,
	input logic [3:0]   m_axis_tuser,
	input logic         m_axis_tlast
);
	import atc_pkg::*;

	// a stalled command stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("command dropped while stalled");

	// op code stays within the defined commands
	a_op: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[2:0] == OP_ECHO || m_axis_tuser[2:0] == OP_GLYPH ||
		                   m_axis_tuser[2:0] == OP_FILL || m_axis_tuser[2:0] == OP_SCROLL ||
		                   m_axis_tuser[2:0] == OP_CLEAR))
		else $error("bad op code");

	// commands without a position carry a zero origin
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[2:0] == OP_ECHO || m_axis_tuser[2:0] == OP_SCROLL ||
		                  m_axis_tuser[2:0] == OP_CLEAR) |-> m_axis_tdata[31:0] == '0)
		else $error("nonzero origin");

	// a command that is not the last of its byte is followed by one echo-free command
	a_second: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
		m_axis_tvalid |-> !m_axis_tuser[3])
		else $error("echo repeated on second command");

endmodule

bind ansi_text_console_cursor_engine atc_checker u_atc_checker (.*);

[tb/ansi_text_console_cursor_engine_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_text_console_cursor_engine_checker
// Watches the byte, command and config ports, predicts the commands of each
// accepted byte from its own copy of cursor, colors, parser and config, and
// compares every command transaction field by field in order.
// ----------------------------------------------------------------------------
module ansi_text_console_cursor_engine_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,   // char_byte, message_color
	input  logic         s_axis_tuser,   // message_start
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [103:0] m_axis_tdata,   // pos_x, pos_y, rect_w, rect_h,
	                                     // draw_color, glyph_code, echo_byte
	input  logic [3:0]   m_axis_tuser,   // op, echo_valid
	input  logic         m_axis_tlast,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [12:0]  cfg_data,
	output int           errors,
	output int           pending,
	output int           cmds_checked
);
	import atc_pkg::*;

	localparam int TAB_CELLS = 4;
	localparam int NPARAM    = 4;

	int unsigned cell_w, cell_h, scr_w, scr_h;
	int unsigned cur_x, cur_y, act_color, base_color;
	logic [1:0]  phase;
	int unsigned params [NPARAM];
	int unsigned param_n, accum;
	logic        digit_seen;

	result_t step_cmds[$];
	result_t expected_cmds[$];

	function automatic int unsigned sat_coord(longint unsigned v);
		return (v > 65535) ? 65535 : int'(v);
	endfunction

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic add_cmd(cmd_op_t op, int unsigned x, int unsigned y,
		int unsigned w, int unsigned h, logic [23:0] color, logic [7:0] glyph);
		result_t r;
		if (step_cmds.size() >= 2)
			return;
		r = '0;
		r.cmd.op = op;
		r.cmd.pos_x = x[15:0];
		r.cmd.pos_y = y[15:0];
		r.cmd.rect_w = w[12:0];
		r.cmd.rect_h = h[12:0];
		r.cmd.draw_color = color;
		r.cmd.glyph_code = glyph;
		step_cmds.push_back(r);
	endtask

	task automatic store_param(int unsigned v);
		if (param_n < NPARAM) begin
			params[param_n] = v;
			param_n++;
		end
		accum = 0;
		digit_seen = 0;
	endtask

	task automatic run_final(logic [7:0] b, int unsigned cw, int unsigned ch, int unsigned maxy);
		int unsigned p, row, col, mode, n;
		if (b == CH_SGR) begin
			if (param_n == 0)
				act_color = base_color;
			for (int i = 0; i < param_n; i++) begin
				p = params[i];
				if (p >= SGR_FG_LO && p <= SGR_FG_HI)
					act_color = palette(4'(p - SGR_FG_LO));
				else if (p >= SGR_BRIGHT_LO && p <= SGR_BRIGHT_HI)
					act_color = palette(4'(8 + p - SGR_BRIGHT_LO));
				else if (p == SGR_RESET)
					act_color = base_color;
			end
		end else if (b == CH_CUP) begin
			row = (param_n > 0) ? params[0] : 1;
			col = (param_n > 1) ? params[1] : 1;
			cur_y = (row > 0) ? sat_coord(longint'(row - 1) * ch) : 0;
			cur_x = (col > 0) ? sat_coord(longint'(col - 1) * cw) : 0;
		end else if (b == CH_ED) begin
			mode = (param_n > 0) ? params[0] : 0;
			if (mode == ERASE_ALL) begin
				add_cmd(OP_CLEAR, 0, 0, 0, 0, '0, '0);
				cur_x = 0;
				cur_y = 0;
			end else if (mode == ERASE_BELOW && cur_y <= maxy) begin
				n = (maxy - cur_y) / ch;
				add_cmd(OP_FILL, cur_x, cur_y, (scr_w > cur_x) ? scr_w - cur_x : 0, ch, '0, '0);
				if (n > 0)
					add_cmd(OP_FILL, 0, cur_y + ch, scr_w, n * ch, '0, '0);
			end
		end else if (b == CH_EL) begin
			mode = (param_n > 0) ? params[0] : 0;
			if (mode == ERASE_BELOW)
				add_cmd(OP_FILL, cur_x, cur_y, (scr_w > cur_x) ? scr_w - cur_x : 0, ch, '0, '0);
		end
	endtask

	task automatic run_text(logic [7:0] b, int unsigned cw, int unsigned ch,
		int unsigned maxx, int unsigned maxy);
		longint unsigned tw;
		if (b == CH_LF) begin
			cur_x = 0;
			cur_y = sat_coord(longint'(cur_y) + ch);
		end else if (b == CH_CR) begin
			cur_x = 0;
		end else if (b == CH_TAB) begin
			tw = longint'(cw) * TAB_CELLS;
			cur_x = sat_coord((cur_x / tw + 1) * tw);
		end else begin
			if (longint'(cur_x) + cw <= scr_w && longint'(cur_y) + ch <= scr_h)
				add_cmd(OP_GLYPH, cur_x, cur_y, 0, 0, act_color[23:0], b);
			cur_x = sat_coord(longint'(cur_x) + cw);
		end
		if (cur_x > maxx) begin
			cur_x = 0;
			cur_y = sat_coord(longint'(cur_y) + ch);
		end
		if (cur_y > maxy && ch < scr_h) begin
			cur_y = (cur_y >= ch) ? cur_y - ch : 0;
			add_cmd(OP_SCROLL, 0, 0, 0, 0, '0, '0);
		end
	endtask

	// one console byte in, zero to two commands out
	task automatic predict_byte(logic [7:0] b, logic start, logic [23:0] color);
		int unsigned cw, ch, maxx, maxy, v;
		logic echo;
		echo = 1;
		if (start) begin
			phase = PH_GROUND;
			param_n = 0;
			accum = 0;
			digit_seen = 0;
			base_color = color;
			act_color = color;
		end
		cw = (cell_w != 0) ? cell_w : 1;
		ch = (cell_h != 0) ? cell_h : 1;
		maxx = (scr_w >= cw) ? scr_w - cw : 0;
		maxy = (scr_h >= ch) ? scr_h - ch : 0;
		step_cmds.delete();
		if (phase == PH_ESC) begin
			if (b == CH_LBR) begin
				phase = PH_CSI;
				param_n = 0;
				accum = 0;
				digit_seen = 0;
			end else begin
				phase = PH_GROUND;
			end
		end else if (phase == PH_CSI) begin
			if (b >= CH_D0 && b <= CH_D9) begin
				v = accum * 10 + (b - CH_D0);
				accum = (v > PARAM_MAX) ? PARAM_MAX : v;
				digit_seen = 1;
				echo = 0;
			end else if (b == CH_SEMI) begin
				store_param(digit_seen ? accum : 0);
			end else begin
				if (digit_seen)
					store_param(accum);
				phase = PH_GROUND;
				run_final(b, cw, ch, maxy);
			end
		end else begin
			phase = PH_GROUND;
			if (b == CH_ESC)
				phase = PH_ESC;
			else
				run_text(b, cw, ch, maxx, maxy);
		end
		if (step_cmds.size() == 0) begin
			if (!echo)
				return;
			add_cmd(OP_ECHO, 0, 0, 0, 0, '0, '0);
		end
		if (echo) begin
			step_cmds[0].echo_valid = 1;
			step_cmds[0].echo_byte = b;
		end
		step_cmds[step_cmds.size() - 1].last = 1;
		foreach (step_cmds[i])
			expected_cmds.push_back(step_cmds[i]);
	endtask

	task automatic compare_cmd();
		result_t want;
		if (expected_cmds.size() == 0) begin
			$display("[%0t] command transaction with nothing expected", $realtime);
			errors++;
			return;
		end
		want = expected_cmds.pop_front();
		cmds_checked++;
		if (m_axis_tuser[2:0] !== want.cmd.op) report("op", m_axis_tuser[2:0], want.cmd.op);
		if (m_axis_tdata[15:0] !== want.cmd.pos_x) report("pos_x", m_axis_tdata[15:0], want.cmd.pos_x);
		if (m_axis_tdata[31:16] !== want.cmd.pos_y) report("pos_y", m_axis_tdata[31:16], want.cmd.pos_y);
		if (m_axis_tdata[44:32] !== want.cmd.rect_w) report("rect_w", m_axis_tdata[44:32], want.cmd.rect_w);
		if (m_axis_tdata[57:45] !== want.cmd.rect_h) report("rect_h", m_axis_tdata[57:45], want.cmd.rect_h);
		if (m_axis_tdata[81:58] !== want.cmd.draw_color)
			report("draw_color", m_axis_tdata[81:58], want.cmd.draw_color);
		if (m_axis_tdata[89:82] !== want.cmd.glyph_code)
			report("glyph_code", m_axis_tdata[89:82], want.cmd.glyph_code);
		if (m_axis_tuser[3] !== want.echo_valid) report("echo_valid", m_axis_tuser[3], want.echo_valid);
		if (m_axis_tdata[97:90] !== want.echo_byte) report("echo_byte", m_axis_tdata[97:90], want.echo_byte);
		if (m_axis_tlast !== want.last) report("tlast", m_axis_tlast, want.last);
	endtask

	initial begin
		errors = 0;
		pending = 0;
		cmds_checked = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_w = RST_CELL_WIDTH;
			cell_h = RST_CELL_HEIGHT;
			scr_w = RST_SCREEN_WIDTH;
			scr_h = RST_SCREEN_HEIGHT;
			cur_x = 0;
			cur_y = 0;
			act_color = RST_COLOR;
			base_color = RST_COLOR;
			phase = PH_GROUND;
			param_n = 0;
			accum = 0;
			digit_seen = 0;
			expected_cmds.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CELL_WIDTH:    cell_w = cfg_data[6:0];
					REG_CELL_HEIGHT:   cell_h = cfg_data[6:0];
					REG_SCREEN_WIDTH:  scr_w = cfg_data;
					REG_SCREEN_HEIGHT: scr_h = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_byte(s_axis_tdata[7:0], s_axis_tuser, s_axis_tdata[31:8]);
			if (m_axis_tvalid && m_axis_tready)
				compare_cmd();
		end
		pending = expected_cmds.size();
	end

endmodule

[tb/ansi_text_console_cursor_engine_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_text_console_cursor_engine_test
// Drives console text, CSI sequences and message starts through the engine
// under several cell and screen settings, with bursty input and a stalling
// command sink; the checker predicts and compares every command.
// ----------------------------------------------------------------------------
module ansi_text_console_cursor_engine_test;
	import atc_pkg::*;

	localparam int NUM_BYTES  = 1900;
	localparam int PHASE_LEN  = 240;
	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE     = 40;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [31:0]  s_axis_tdata = '0;
	logic         s_axis_tuser = 0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [103:0] m_axis_tdata;
	logic [3:0]   m_axis_tuser;
	logic         m_axis_tlast;
	logic         cfg_we = 0;
	logic [1:0]   cfg_index = '0;
	logic [12:0]  cfg_data = '0;

	int errors, pending, cmds_checked;
	int bytes_sent, settings_run, burst_left;
	int idle_cycles = 0;
	int sink_mode = 0;
	int sink_left = 0;
	logic [23:0] msg_color;

	always #5 clk = ~clk;

	ansi_text_console_cursor_engine u_top (.*);

	ansi_text_console_cursor_engine_checker u_checker (.*);

	// command sink: runs of always-ready, random, and long stalls
	always @(posedge clk) begin
		if (sink_left == 0) begin
			sink_mode <= $urandom_range(0, 2);
			sink_left <= $urandom_range(4, 40);
		end else begin
			sink_left <= sink_left - 1;
		end
		case (sink_mode)
			0: m_axis_tready <= 1;
			1: m_axis_tready <= $urandom_range(0, 1);
			default: m_axis_tready <= (sink_left % 16) < 3;
		endcase
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_byte(logic [7:0] b, logic start = 0);
		int gap;
		logic ok;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		if (start)
			msg_color = 24'($urandom_range(0, 24'hFFFFFF));
		s_axis_tvalid <= 1;
		s_axis_tdata <= {msg_color, b};
		s_axis_tuser <= start;
		do begin
			@(negedge clk);
			ok = s_axis_tready;
			@(posedge clk);
		end while (!ok);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_number(int unsigned v);
		string s;
		s = $sformatf("%0d", v);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [12:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_setting(int k);
		logic [12:0] cw, ch, sw, sh;
		case (k % 6)
			0: begin cw = 1; ch = 1; sw = 1; sh = 1; end
			1: begin cw = 64; ch = 64; sw = 8191; sh = 8191; end
			2: begin cw = 0; ch = 127; sw = 8191; sh = 100; end
			3: begin cw = 64; ch = 64; sw = 10; sh = 10; end
			4: begin
				cw = $urandom_range(1, 64); ch = $urandom_range(1, 64);
				sw = $urandom_range(1, 8191); sh = $urandom_range(1, 8191);
			end
			default: begin cw = 8; ch = 16; sw = 80; sh = 64; end
		endcase
		write_reg(REG_CELL_WIDTH, cw);
		write_reg(REG_CELL_HEIGHT, ch);
		write_reg(REG_SCREEN_WIDTH, sw);
		write_reg(REG_SCREEN_HEIGHT, sh);
		cfg_we <= 0;
		settings_run++;
	endtask

	task automatic send_param();
		case ($urandom_range(0, 7))
			0: send_number($urandom_range(0, 3));
			1: send_number($urandom_range(30, 37));
			2: send_number($urandom_range(90, 97));
			3: send_number($urandom_range(0, 300));
			4: send_number(65535);
			5: repeat ($urandom_range(6, 8)) send_byte(CH_D0 + $urandom_range(0, 9));
			6: ;
			default: send_number($urandom_range(1, 40));
		endcase
	endtask

	// ESC [ params final; sometimes broken or with an unknown final
	task automatic send_csi();
		int np;
		logic [7:0] fin;
		send_byte(CH_ESC);
		if ($urandom_range(0, 15) == 0) begin
			send_byte($urandom_range(0, 255));
			return;
		end
		send_byte(CH_LBR);
		np = $urandom_range(0, 6);
		for (int i = 0; i < np; i++) begin
			send_param();
			if (i != np - 1 || $urandom_range(0, 5) == 0)
				send_byte(CH_SEMI);
		end
		case ($urandom_range(0, 9))
			0, 1, 2: fin = CH_SGR;
			3, 4: fin = CH_CUP;
			5, 6: fin = CH_ED;
			7: fin = CH_EL;
			8: fin = $urandom_range(0, 255);
			default: fin = CH_ESC;
		endcase
		if (fin >= CH_D0 && fin <= CH_D9)
			fin = CH_SGR;
		send_byte(fin);
	endtask

	task automatic send_random_item();
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5: send_csi();
			6: send_byte(CH_LF, $urandom_range(0, 1));
			7: send_byte(CH_CR);
			8: send_byte(CH_TAB);
			9: send_byte($urandom_range(0, 255), $urandom_range(0, 1));
			10: send_byte($urandom_range(0, 255));
			default: send_byte($urandom_range(32, 126), $urandom_range(0, 20) == 0);
		endcase
	endtask

	initial begin
		burst_left = 0;
		bytes_sent = 0;
		settings_run = 1;
		msg_color = 24'hFFFFFF;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: plain text, controls, colors, erase, extremes of the byte
		send_byte("A", 1);
		send_byte(CH_TAB);
		send_byte(CH_LF);
		send_byte(CH_CR);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_ESC); send_byte(CH_LBR); send_byte("3"); send_byte("1"); send_byte(CH_SGR);
		send_byte("B");
		send_byte(CH_ESC); send_byte(CH_LBR); send_byte("9"); send_byte("7"); send_byte(CH_SGR);
		send_byte(CH_ESC); send_byte(CH_LBR); send_byte(CH_SGR);
		send_byte(CH_ESC); send_byte("x");
		send_byte(CH_ESC); send_byte(CH_LBR); send_byte(CH_EL);
		send_byte(CH_ESC); send_byte(CH_LBR); send_byte(CH_ED);

		while (bytes_sent < NUM_BYTES) begin
			if (bytes_sent / PHASE_LEN >= settings_run) begin
				drain();
				load_setting(settings_run - 1);
			end
			send_random_item();
		end
		drain();

		$display("%0d console bytes over %0d cell/screen settings; %0d commands checked",
			bytes_sent, settings_run, cmds_checked);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[filelist.f]
sv/atc_pkg.sv
sv/atc_front.sv
sv/atc_div.sv
sv/atc_back.sv
sv/ansi_text_console_cursor_engine.sv
sv/atc_checker.sv
tb/ansi_text_console_cursor_engine_checker.sv
tb/ansi_text_console_cursor_engine_test.sv
